// ===== hdl/heap_sort_engine_macros.svh =====
// Assertion shorthands for the heap sort engine.
// Both expect signals named clk and rst in the scope of use.
`ifndef HEAP_SORT_ENGINE_MACROS_SVH
`define HEAP_SORT_ENGINE_MACROS_SVH

// Same-cycle implication.
`define HSE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hse_pkg.sv =====
`timescale 1ns / 1ps

package hse_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int KEY_W     = 32;
  localparam int CMP_W     = 32;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [CMP_W-1:0]        cmp_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_BUILD_NEXT,
    ST_SIFT_HELD,
    ST_SIFT_CHECK,
    ST_SIFT_CMP,
    ST_EXT_READ,
    ST_EXT_SWAP,
    ST_EXT_PUT,
    ST_EMIT_READ,
    ST_EMIT_WAIT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic store_key;
    logic begin_sort;
    logic read_held;
    logic take_held;
    logic read_children;
    logic write_held;
    logic descend;
    logic dec_k;
    logic read_ext;
    logic swap_root;
    logic write_top;
    logic read_emit;
    logic next_emit;
    logic finish;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic k_zero;
    logic has_child;
    logic go_down;
    logic heap_zero;
    logic emit_last;
  } stat_t;

endpackage

// ===== hdl/hse_key_if.sv =====
`timescale 1ns / 1ps

interface hse_key_if;
  logic                valid;
  logic                ready;
  hse_pkg::key_t       key_in;
  logic                last_in;

  modport source (output valid, output key_in, output last_in, input ready);
  modport sink   (input valid, input key_in, input last_in, output ready);
endinterface

// ===== hdl/hse_result_if.sv =====
`timescale 1ns / 1ps

interface hse_result_if;
  logic                valid;
  logic                ready;
  hse_pkg::key_t       key_out;
  logic                last_out;
  hse_pkg::cmp_t       comparisons;
  logic                overflow;

  modport source (output valid, output key_out, output last_out,
                  output comparisons, output overflow, input ready);
  modport sink   (input valid, input key_out, input last_out,
                  input comparisons, input overflow, output ready);
endinterface

// ===== hdl/heap_sort_engine.sv =====
// Load: one key word per clock; the key marked last closes the set.
// Sort: paced by the single two-read, one-write key memory: each sift-down level reads both
// children, then compares and writes; each extract adds a read, a root swap and a top write.
// Output: each sorted word is read, then held until the sink is ready; no overlap between sets.
// Reset (rst, synchronous, active high) empties the set and returns to loading.
`timescale 1ns / 1ps

module heap_sort_engine (
  input  logic           clk,
  input  logic           rst,
  hse_key_if.sink        keys,
  hse_result_if.source   sorted
);
  import hse_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: load, heap build, root extraction and emission, one set at a time.
  hse_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (keys.valid),
    .in_last   (keys.last_in),
    .in_ready  (keys.ready),
    .out_valid (sorted.valid),
    .out_ready (sorted.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Key memory, sift-down compare, counters and the result word.
  // The registered read port holds the key on the output while a word waits.
  hse_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .key_in      (keys.key_in),
    .key_out     (sorted.key_out),
    .last_out    (sorted.last_out),
    .comparisons (sorted.comparisons),
    .overflow    (sorted.overflow)
  );

endmodule

// ===== hdl/hse_datapath.sv =====
`timescale 1ns / 1ps

module hse_datapath (
  input  logic           clk,
  input  logic           rst,
  input  hse_pkg::cmd_t  cmd,
  output hse_pkg::stat_t stat,
  input  hse_pkg::key_t  key_in,
  output hse_pkg::key_t  key_out,
  output logic           last_out,
  output hse_pkg::cmp_t  comparisons,
  output logic           overflow
);
  import hse_pkg::*;

  key_t mem [MAX_ITEMS];
  key_t rd_a;
  key_t rd_b;
  key_t held;
  key_t top;

  cnt_t count;
  cnt_t n_items;
  cnt_t heap;
  cnt_t k;
  cnt_t node;
  cmp_t comps;
  logic dropped;

  logic [CNT_W:0] child;
  logic [CNT_W:0] child_m1;
  cnt_t           node_m1;
  logic           pick_right;
  key_t           sel;
  cnt_t           sel_idx;
  logic           full;

  logic  wr_en;
  addr_t wr_addr;
  key_t  wr_data;
  logic  rd_a_en;
  addr_t rd_a_addr;
  logic  rd_b_en;
  addr_t rd_b_addr;

  assign child      = {node, 1'b0};
  assign child_m1   = child - {{CNT_W{1'b0}}, 1'b1};
  assign node_m1    = node - cnt_t'(1);
  assign full       = (count == cnt_t'(MAX_ITEMS));
  // right child exists only while its index does not exceed the heap size
  assign pick_right = (child < {1'b0, heap}) && (rd_a < rd_b);
  assign sel        = pick_right ? rd_b : rd_a;
  assign sel_idx    = pick_right ? child[CNT_W-1:0] + cnt_t'(1) : child[CNT_W-1:0];

  assign stat.k_zero    = (k == '0);
  assign stat.has_child = (child <= {1'b0, heap});
  assign stat.go_down   = (held < sel);
  assign stat.heap_zero = (heap == '0);
  assign stat.emit_last = (k == n_items - cnt_t'(1));

  assign key_out     = rd_a;
  assign last_out    = stat.emit_last;
  assign comparisons = stat.emit_last ? comps : '0;
  assign overflow    = dropped;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = held;
    if (cmd.store_key && !full) begin
      wr_en   = 1'b1;
      wr_addr = count[ADDR_W-1:0];
      wr_data = key_in;
    end else if (cmd.write_held) begin
      wr_en   = 1'b1;
      wr_addr = node_m1[ADDR_W-1:0];
      wr_data = held;
    end else if (cmd.descend) begin
      wr_en   = 1'b1;
      wr_addr = node_m1[ADDR_W-1:0];
      wr_data = sel;
    end else if (cmd.write_top) begin
      wr_en   = 1'b1;
      wr_addr = heap[ADDR_W-1:0];
      wr_data = top;
    end
  end

  always_comb begin
    rd_a_en   = 1'b1;
    rd_a_addr = '0;
    rd_b_en   = 1'b0;
    rd_b_addr = '0;
    if (cmd.read_held) begin
      rd_a_addr = k[ADDR_W-1:0] - addr_t'(1);
    end else if (cmd.read_children) begin
      rd_a_addr = child_m1[ADDR_W-1:0];
      rd_b_en   = 1'b1;
      rd_b_addr = child[ADDR_W-1:0];
    end else if (cmd.read_ext) begin
      rd_b_en   = 1'b1;
      rd_b_addr = heap[ADDR_W-1:0] - addr_t'(1);
    end else if (cmd.read_emit) begin
      rd_a_addr = k[ADDR_W-1:0];
    end else begin
      rd_a_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a <= mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b <= mem[rd_b_addr];
    end
    if (cmd.take_held) begin
      held <= rd_a;
    end
    if (cmd.swap_root) begin
      top  <= rd_a;
      held <= rd_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      n_items <= '0;
      heap    <= '0;
      k       <= '0;
      node    <= '0;
      comps   <= '0;
      dropped <= 1'b0;
    end else begin
      if (cmd.store_key) begin
        if (full) begin
          dropped <= 1'b1;
        end else begin
          count <= count + cnt_t'(1);
        end
      end
      if (cmd.begin_sort) begin
        heap    <= count;
        n_items <= count;
        k       <= count >> 1;
        comps   <= '0;
      end
      if (cmd.read_held) begin
        node <= k;
      end
      if (cmd.read_children) begin
        comps <= comps + cmp_t'(2);
      end
      if (cmd.descend) begin
        node <= sel_idx;
      end
      if (cmd.dec_k) begin
        k <= k - cnt_t'(1);
      end
      if (cmd.swap_root) begin
        heap <= heap - cnt_t'(1);
        node <= cnt_t'(1);
      end
      if (cmd.next_emit) begin
        k <= k + cnt_t'(1);
      end
      if (cmd.finish) begin
        count   <= '0;
        heap    <= '0;
        k       <= '0;
        comps   <= '0;
        dropped <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/hse_controller.sv =====
`timescale 1ns / 1ps

module hse_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  hse_pkg::stat_t stat,
  output hse_pkg::cmd_t  cmd
);
  import hse_pkg::*;

  state_t state;
  state_t state_next;
  logic   build_phase;
  logic   build_phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      build_phase <= 1'b0;
    end else begin
      state       <= state_next;
      build_phase <= build_phase_next;
    end
  end

  always_comb begin
    cmd              = '0;
    in_ready         = 1'b0;
    out_valid        = 1'b0;
    state_next       = state;
    build_phase_next = build_phase;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.store_key = 1'b1;
          if (in_last) begin
            state_next = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd.begin_sort   = 1'b1;
        build_phase_next = 1'b1;
        state_next       = ST_BUILD_NEXT;
      end
      ST_BUILD_NEXT: begin
        if (stat.k_zero) begin
          build_phase_next = 1'b0;
          state_next       = ST_EXT_READ;
        end else begin
          cmd.read_held = 1'b1;
          state_next    = ST_SIFT_HELD;
        end
      end
      ST_SIFT_HELD: begin
        cmd.take_held = 1'b1;
        state_next    = ST_SIFT_CHECK;
      end
      ST_SIFT_CHECK: begin
        if (stat.has_child) begin
          cmd.read_children = 1'b1;
          state_next        = ST_SIFT_CMP;
        end else begin
          cmd.write_held = 1'b1;
          cmd.dec_k      = build_phase;
          state_next     = build_phase ? ST_BUILD_NEXT : ST_EXT_PUT;
        end
      end
      ST_SIFT_CMP: begin
        if (stat.go_down) begin
          cmd.descend = 1'b1;
          state_next  = ST_SIFT_CHECK;
        end else begin
          cmd.write_held = 1'b1;
          cmd.dec_k      = build_phase;
          state_next     = build_phase ? ST_BUILD_NEXT : ST_EXT_PUT;
        end
      end
      ST_EXT_READ: begin
        cmd.read_ext = 1'b1;
        state_next   = ST_EXT_SWAP;
      end
      ST_EXT_SWAP: begin
        cmd.swap_root = 1'b1;
        state_next    = ST_SIFT_CHECK;
      end
      ST_EXT_PUT: begin
        cmd.write_top = 1'b1;
        state_next    = stat.heap_zero ? ST_EMIT_READ : ST_EXT_READ;
      end
      ST_EMIT_READ: begin
        cmd.read_emit = 1'b1;
        state_next    = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.emit_last) begin
            cmd.finish = 1'b1;
            state_next = ST_LOAD;
          end else begin
            cmd.next_emit = 1'b1;
            state_next    = ST_EMIT_READ;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== hdl/hse_checker.sv =====
`timescale 1ns / 1ps
`include "heap_sort_engine_macros.svh"

module hse_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          in_last,
  input logic          out_valid,
  input logic          out_ready,
  input hse_pkg::key_t out_key,
  input logic          out_last,
  input hse_pkg::cmp_t out_comparisons
);

  // Hold a stalled result word.
  `HSE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_key), "stalled result changed")

  // Never load and emit at once.
  `HSE_ASSERT_SAME(a_no_overlap, in_ready, !out_valid, "input ready while a result is shown")

  // Count shows only on the final word.
  `HSE_ASSERT_SAME(a_cmp_last, out_valid && !out_last, out_comparisons == '0, "count on non-final word")

  // Closing key starts the sort.
  `HSE_ASSERT_NEXT(a_close, in_valid && in_ready && in_last, !in_ready, "input still open after last key")

endmodule

bind heap_sort_engine hse_checker u_hse_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (keys.valid),
  .in_ready        (keys.ready),
  .in_last         (keys.last_in),
  .out_valid       (sorted.valid),
  .out_ready       (sorted.ready),
  .out_key         (sorted.key_out),
  .out_last        (sorted.last_out),
  .out_comparisons (sorted.comparisons)
);
